@@ rtl/cab_pkg.sv @@
// cab_pkg: shared widths, register indexes, reset values and the divide-by-255 helper
// for the cursor alpha blender; used by cursor_alpha_blend and cab_checker
// depends on nothing
package cab_pkg;

    // fixed field widths
    localparam int CHAN_BITS       = 8;
    localparam int REG_BITS        = 13;
    localparam int ADDR_BITS       = 24;
    localparam int WORD_BITS       = 32;
    localparam int MIX_BITS        = 16;
    localparam int COORD_BITS_DEF  = 13;
    localparam int CFG_INDEX_BITS  = 1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    // register reset values
    localparam logic [REG_BITS-1:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [REG_BITS-1:0] FRAME_HEIGHT_RST = 13'd1080;

    // full-scale channel value
    localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hFF;

    // exact floor(v/255) for v up to 255*255: (v + (v>>8) + 1) >> 8
    function automatic logic [CHAN_BITS-1:0] div255(input logic [MIX_BITS-1:0] v);
        logic [MIX_BITS:0] t;
        t = {1'b0, v} + {9'd0, v[MIX_BITS-1:CHAN_BITS]} + {{MIX_BITS{1'b0}}, 1'b1};
        return CHAN_BITS'(t >> CHAN_BITS);
    endfunction

endpackage

@@ rtl/cursor_alpha_blend.sv @@
// cursor_alpha_blend: three-stage source-over blender for ARGB8888 cursor pixels
// depends on cab_pkg (widths, register indexes, div255)
//
// Usage
//   Input channel: drive the pixel fields and pulse i_start; a beat is taken at every
//   rising edge with i_start high and o_busy low. o_busy stays low, so one beat per
//   clock is taken with no gaps.
//   Result channel: o_valid marks one result beat for exactly one cycle, carrying
//   o_write_enable, o_write_address and o_blended_word. The receiver must take it;
//   there is no back-pressure and nothing in the pipe ever waits.
//   Throughput is one pixel per clock; each beat passes through the three register
//   stages (products, sums, divide by 255 and pack) on its way to its result beat.
//   Out-of-bounds or fully transparent pixels still give a result beat, with write
//   enable, address and word all zero.
//   Configuration: i_cfg_we with i_cfg_index / i_cfg_data writes frame width or
//   height at the edge; write only while no beat is in flight.
//   Reset (synchronous, active low) empties the pipe and restores 1920 x 1080.
module cursor_alpha_blend #(
    parameter int COORD_BITS = cab_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                i_cfg_we,
    input  logic [cab_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [cab_pkg::REG_BITS-1:0]        i_cfg_data,
    // input beat
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [COORD_BITS-1:0]               i_pos_x,
    input  logic [COORD_BITS-1:0]               i_pos_y,
    input  logic [cab_pkg::CHAN_BITS-1:0]       i_src_red,
    input  logic [cab_pkg::CHAN_BITS-1:0]       i_src_green,
    input  logic [cab_pkg::CHAN_BITS-1:0]       i_src_blue,
    input  logic [cab_pkg::CHAN_BITS-1:0]       i_src_alpha,
    input  logic [cab_pkg::WORD_BITS-1:0]       i_dest_word,
    // result beat
    output logic                                o_valid,
    output logic                                o_write_enable,
    output logic [cab_pkg::ADDR_BITS-1:0]       o_write_address,
    output logic [cab_pkg::WORD_BITS-1:0]       o_blended_word
);
    import cab_pkg::*;

    localparam int CMP_BITS = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
    localparam int PROD_BITS = COORD_BITS + REG_BITS;
    localparam int MUL_BITS = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS;

    // configuration registers
    logic [REG_BITS-1:0] r_frame_width;
    logic [REG_BITS-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the pipe never stalls
    assign o_busy = 1'b0;

    logic accept;
    assign accept = i_start && !o_busy;

    // stage 1: bounds check and all products
    logic                 n_keep1;
    logic [CHAN_BITS-1:0] n_inv_a;
    logic [ADDR_BITS-1:0] n_row_prod;

    logic                 r_v1;
    logic                 r_keep1;
    logic [CHAN_BITS-1:0] r_sa1;
    logic [MIX_BITS-1:0]  r_sr_p, r_sg_p, r_sb_p;
    logic [MIX_BITS-1:0]  r_dr_p, r_dg_p, r_db_p, r_da_p;
    logic [ADDR_BITS-1:0] r_row_base;
    logic [COORD_BITS-1:0] r_x1;

    always_comb begin
        n_keep1 = (CMP_BITS'(i_pos_x) < CMP_BITS'(r_frame_width))
               && (CMP_BITS'(i_pos_y) < CMP_BITS'(r_frame_height))
               && (i_src_alpha != '0);
        n_inv_a = CHAN_MAX - i_src_alpha;
        n_row_prod = ADDR_BITS'(MUL_BITS'(i_pos_y) * MUL_BITS'(r_frame_width));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_keep1    <= n_keep1;
        r_sa1      <= i_src_alpha;
        r_sr_p     <= MIX_BITS'(i_src_red)   * MIX_BITS'(i_src_alpha);
        r_sg_p     <= MIX_BITS'(i_src_green) * MIX_BITS'(i_src_alpha);
        r_sb_p     <= MIX_BITS'(i_src_blue)  * MIX_BITS'(i_src_alpha);
        r_dr_p     <= MIX_BITS'(i_dest_word[23:16]) * MIX_BITS'(n_inv_a);
        r_dg_p     <= MIX_BITS'(i_dest_word[15:8])  * MIX_BITS'(n_inv_a);
        r_db_p     <= MIX_BITS'(i_dest_word[7:0])   * MIX_BITS'(n_inv_a);
        r_da_p     <= MIX_BITS'(i_dest_word[31:24]) * MIX_BITS'(n_inv_a);
        r_row_base <= n_row_prod;
        r_x1       <= i_pos_x;
    end

    // stage 2: channel sums and linear address
    logic                 r_v2;
    logic                 r_keep2;
    logic [CHAN_BITS-1:0] r_sa2;
    logic [MIX_BITS-1:0]  r_mix_r, r_mix_g, r_mix_b, r_mix_a;
    logic [ADDR_BITS-1:0] r_addr2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_keep2 <= r_keep1;
        r_sa2   <= r_sa1;
        r_mix_r <= r_sr_p + r_dr_p;
        r_mix_g <= r_sg_p + r_dg_p;
        r_mix_b <= r_sb_p + r_db_p;
        r_mix_a <= r_da_p;
        r_addr2 <= r_row_base + ADDR_BITS'(r_x1);
    end

    // stage 3: divide by 255, pack, zero dropped pixels
    logic [CHAN_BITS-1:0] n_out_a;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        n_out_a = r_sa2 + div255(r_mix_a);
        n_word  = {n_out_a, div255(r_mix_r), div255(r_mix_g), div255(r_mix_b)};
    end

    logic                 r_valid;
    logic                 r_we;
    logic [ADDR_BITS-1:0] r_addr;
    logic [WORD_BITS-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_we    <= 1'b0;
        end else begin
            r_valid <= r_v2;
            r_we    <= r_v2 && r_keep2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= r_keep2 ? r_addr2 : '0;
        r_word <= r_keep2 ? n_word  : '0;
    end

    assign o_valid         = r_valid;
    assign o_write_enable  = r_we;
    assign o_write_address = r_addr;
    assign o_blended_word  = r_word;

endmodule

@@ rtl/cab_checker.sv @@
// cab_checker: port-level checks on cursor_alpha_blend, attached by bind
// depends on cab_pkg (widths) and the cursor_alpha_blend port list
module cab_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           o_busy,
    input  logic                           o_valid,
    input  logic                           o_write_enable,
    input  logic [cab_pkg::ADDR_BITS-1:0]  o_write_address,
    input  logic [cab_pkg::WORD_BITS-1:0]  o_blended_word
);
    import cab_pkg::*;

    // every input beat gives a later result beat
    a_beat_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##3 o_valid)
        else $error("input beat lost");

    // no result beat without an earlier input beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |-> ##3 !o_valid)
        else $error("result beat without input");

    // write enable only inside a result beat
    a_we_in_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_enable |-> o_valid)
        else $error("write enable outside result beat");

    // dropped pixel carries zero address and word
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |-> (o_write_address == '0 && o_blended_word == '0))
        else $error("dropped pixel with nonzero payload");

endmodule

bind cursor_alpha_blend cab_checker u_cab_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_valid         (o_valid),
    .o_write_enable  (o_write_enable),
    .o_write_address (o_write_address),
    .o_blended_word  (o_blended_word)
);
